### src/pmu_pkg.sv
// pmu_pkg: shared types and codes of the particle motion update core.
// Holds the sequencer state type, the particle table entry layout and register codes.
// No dependencies.
`default_nettype none

package pmu_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_DROP,
    ST_DIR,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT,
    ST_DIV_GO,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_WB
  } pmu_state_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] speed;
    logic        [30:0] limit;
    logic        [30:0] elapsed;
  } pmu_entry_t;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_LOOP  = 3'd1;
  localparam logic [2:0] REG_COUNT = 3'd2;
  localparam logic [2:0] REG_PIVX  = 3'd3;
  localparam logic [2:0] REG_PIVY  = 3'd4;
  localparam logic [2:0] REG_PIVZ  = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic MODE_DROP = 1'b0;

endpackage

`default_nettype wire

### src/pmu_ram.sv
// pmu_ram: generic single-port-write, single-port-read RAM with registered read.
// Width and depth set by parameters. No dependencies.
`default_nettype none

module pmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/pmu_sqrt.sv
// pmu_sqrt: iterative integer square root, two radicand bits per cycle.
// Floor of the root of a 62-bit value. No dependencies.
`default_nettype none

module pmu_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [61:0] radicand_i,
  output logic             done_o,
  output logic      [30:0] root_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {2'b00, radicand_i};
      res_d  = '0;
      bit_d  = 64'd1 << 62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[30:0];

endmodule

`default_nettype wire

### src/pmu_div.sv
// pmu_div: iterative restoring divider, one quotient bit per cycle.
// 46-bit dividend over a 31-bit divisor, low 17 quotient bits kept.
// No dependencies.
`default_nettype none

module pmu_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [45:0] dividend_i,
  input  wire logic [30:0] divisor_i,
  output logic             done_o,
  output logic      [16:0] quotient_o
);

  logic [45:0] dvd_q, dvd_d;
  logic [30:0] rem_q, rem_d;
  logic [30:0] dsr_q, dsr_d;
  logic [16:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] trial;

  assign trial = {rem_q, dvd_q[45]};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = 6'd45;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 31'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = trial[30:0];
        quo_d = {quo_q[15:0], 1'b0};
      end
      dvd_d = {dvd_q[44:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### src/particle_motion_update_core.sv
// particle_motion_update_core: particle table in one RAM, updated entry by entry on each tick.
// A load word writes one particle and gives no result. A tick word walks
// particles 0 .. active_count-1 one at a time: read, update, write back, emit one word.
// Drop mode moves a particle down in y by its step. Spread mode, unless the particle sits on
// the pivot, runs one square root and three divisions (one per axis) that normalise the
// direction; write back waits while the output word has not been taken.
// A new input word is taken only once the tick in progress has written its last particle.
// Depends on pmu_pkg, pmu_ram, pmu_sqrt and pmu_div.
`default_nettype none

module particle_motion_update_core #(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // slot[5:0], start_x[37:6], start_y[69:38], start_z[101:70], speed[133:102],
  // life_limit[164:134], time_delta[195:165], zero[199:196]
  input  wire logic [199:0] s_axis_tdata_i,
  // opcode[0]
  input  wire logic [0:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // particle_index[5:0], pos_x[37:6], pos_y[69:38], pos_z[101:70], zero[103:102]
  output logic      [103:0] m_axis_tdata_o,
  // restarted[0]
  output logic      [0:0]   m_axis_tuser_o,
  output logic              m_axis_tlast_o,
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [4:0]   paddr_i,
  input  wire logic [31:0]  pwdata_i,
  output logic      [31:0]  prdata_o,
  output logic              pready_o
);

  import pmu_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int IW = $clog2(MAX_PARTICLES + 1);

  // configuration
  logic               mode_q, loop_q;
  logic [6:0]         count_q;
  logic signed [31:0] piv_q [3];
  logic               cfg_we;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      loop_q   <= 1'b0;
      count_q  <= 7'd1;
      piv_q[0] <= '0;
      piv_q[1] <= '0;
      piv_q[2] <= '0;
    end else if (cfg_we) begin
      unique case (paddr_i[4:2])
        REG_MODE:  mode_q   <= pwdata_i[0];
        REG_LOOP:  loop_q   <= pwdata_i[0];
        REG_COUNT: count_q  <= pwdata_i[6:0];
        REG_PIVX:  piv_q[0] <= pwdata_i;
        REG_PIVY:  piv_q[1] <= pwdata_i;
        REG_PIVZ:  piv_q[2] <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:2])
      REG_MODE:  prdata_o = {31'd0, mode_q};
      REG_LOOP:  prdata_o = {31'd0, loop_q};
      REG_COUNT: prdata_o = {25'd0, count_q};
      REG_PIVX:  prdata_o = piv_q[0];
      REG_PIVY:  prdata_o = piv_q[1];
      REG_PIVZ:  prdata_o = piv_q[2];
      default:   prdata_o = '0;
    endcase
  end

  // input fields
  logic [5:0]         in_slot;
  logic signed [31:0] in_sx, in_sy, in_sz, in_speed;
  logic [30:0]        in_life, in_dt;

  assign in_slot  = s_axis_tdata_i[5:0];
  assign in_sx    = s_axis_tdata_i[37:6];
  assign in_sy    = s_axis_tdata_i[69:38];
  assign in_sz    = s_axis_tdata_i[101:70];
  assign in_speed = s_axis_tdata_i[133:102];
  assign in_life  = s_axis_tdata_i[164:134];
  assign in_dt    = s_axis_tdata_i[195:165];

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v[51:31] == {21{v[51]}}) begin
      r = v[31:0];
    end else if (v[51]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // sequencer registers
  pmu_state_e         state_q, state_d;
  logic [IW-1:0]      idx_q, idx_d, n_q, n_d, n_eff;
  logic [30:0]        dt_q, dt_d;
  pmu_entry_t         ent_q, ent_d;
  logic signed [47:0] step_q, step_d;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] pos_d [3];
  logic [29:0]        mag_q [3];
  logic [29:0]        mag_d [3];
  logic [2:0]         neg_q, neg_d;
  logic [61:0]        sum_q, sum_d;
  logic [1:0]         ax_q, ax_d;
  logic [30:0]        len_q, len_d;
  logic [16:0]        quo_q, quo_d;
  logic signed [65:0] mv_q, mv_d;

  // output register
  logic               ov_q;
  logic [103:0]       odata_q, odata_d;
  logic               orst_q, orst_d, olast_q, olast_d;
  logic               out_load, out_free;

  // RAM ports
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  pmu_entry_t         ram_wdata, ram_rdata, load_ent, wb_ent;

  // arithmetic
  logic signed [63:0] step_prod;
  logic [59:0]        sq_prod;
  logic signed [17:0] u_s;
  logic signed [65:0] mv_prod;
  logic signed [32:0] dvec [3];
  logic [32:0]        dmag [3];
  logic [32:0]        dor;
  logic [31:0]        el_sum;
  logic [30:0]        el_sat;
  logic               restart, last_p, in_take, load_ok;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [30:0]        sq_root;
  logic [16:0]        dv_quo;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_take  = s_axis_tvalid_i & s_axis_tready_o;
  assign load_ok  = ({26'd0, in_slot} < 32'(MAX_PARTICLES));
  assign out_free = ~ov_q | m_axis_tready_i;
  assign n_eff    = (32'(count_q) > 32'(MAX_PARTICLES)) ? IW'(MAX_PARTICLES) : IW'(count_q);
  assign last_p   = ((idx_q + IW'(1)) == n_q);

  assign step_prod = ram_rdata.speed * $signed({1'b0, dt_q});
  assign sq_prod   = mag_q[ax_q] * mag_q[ax_q];
  assign u_s       = neg_q[ax_q] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign mv_prod   = u_s * step_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvec[k] = {pos_q[k][31], pos_q[k]} - {piv_q[k][31], piv_q[k]};
      dmag[k] = dvec[k][32] ? 33'(-dvec[k]) : 33'(dvec[k]);
    end
    dor = dmag[0] | dmag[1] | dmag[2];
  end

  assign el_sum  = {1'b0, ent_q.elapsed} + {1'b0, dt_q};
  assign el_sat  = el_sum[31] ? 31'h7FFF_FFFF : el_sum[30:0];
  assign restart = loop_q & (el_sat > ent_q.limit);

  always_comb begin
    load_ent         = '0;
    load_ent.start_x = in_sx;
    load_ent.start_y = in_sy;
    load_ent.start_z = in_sz;
    load_ent.cur_x   = in_sx;
    load_ent.cur_y   = in_sy;
    load_ent.cur_z   = in_sz;
    load_ent.speed   = in_speed;
    load_ent.limit   = in_life;
    load_ent.elapsed = '0;
    wb_ent           = ent_q;
    wb_ent.cur_x     = restart ? ent_q.start_x : pos_q[0];
    wb_ent.cur_y     = restart ? ent_q.start_y : pos_q[1];
    wb_ent.cur_z     = restart ? ent_q.start_z : pos_q[2];
    wb_ent.elapsed   = restart ? 31'd0 : el_sat;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    n_d      = n_q;
    dt_d     = dt_q;
    ent_d    = ent_q;
    step_d   = step_q;
    pos_d    = pos_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    sum_d    = sum_q;
    ax_d     = ax_q;
    len_d    = len_q;
    quo_d    = quo_q;
    mv_d     = mv_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_waddr = AW'(idx_q);
    ram_wdata = wb_ent;
    sq_start = 1'b0;
    dv_start = 1'b0;
    out_load = 1'b0;
    odata_d  = {2'b00, wb_ent.cur_z, wb_ent.cur_y, wb_ent.cur_x, 6'(idx_q)};
    orst_d   = restart;
    olast_d  = last_p;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (s_axis_tuser_i[0] == OP_TICK) begin
            n_d   = n_eff;
            idx_d = '0;
            dt_d  = in_dt;
            if (n_eff != '0) begin
              state_d = ST_READ;
            end
          end else if (load_ok) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(in_slot);
            ram_wdata = load_ent;
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        ent_d    = ram_rdata;
        step_d   = step_prod[63:16];
        pos_d[0] = ram_rdata.cur_x;
        pos_d[1] = ram_rdata.cur_y;
        pos_d[2] = ram_rdata.cur_z;
        state_d  = (mode_q == MODE_DROP) ? ST_DROP : ST_DIR;
      end
      ST_DROP: begin
        pos_d[1] = sat32(52'(pos_q[1]) - 52'(step_q));
        state_d  = ST_WB;
      end
      ST_DIR: begin
        for (int k = 0; k < 3; k++) begin
          neg_d[k] = dvec[k][32];
          if (dor[32]) begin
            mag_d[k] = dmag[k][32:3];
          end else if (dor[31]) begin
            mag_d[k] = dmag[k][31:2];
          end else if (dor[30]) begin
            mag_d[k] = dmag[k][30:1];
          end else begin
            mag_d[k] = dmag[k][29:0];
          end
        end
        sum_d   = '0;
        ax_d    = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sum_d = sum_q + {2'b00, sq_prod};
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = ST_ROOT_GO;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      ST_ROOT_GO: begin
        if (sum_q == '0) begin
          state_d = ST_WB;
        end else begin
          sq_start = 1'b1;
          state_d  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          len_d   = sq_root;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        dv_start = 1'b1;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (dv_done) begin
          quo_d   = dv_quo;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mv_d    = mv_prod;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        pos_d[ax_q] = sat32(52'(pos_q[ax_q]) + 52'($signed(mv_q[65:16])));
        if (ax_q == 2'd2) begin
          state_d = ST_WB;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_DIV_GO;
        end
      end
      ST_WB: begin
        if (out_free) begin
          ram_we   = 1'b1;
          out_load = 1'b1;
          idx_d    = idx_q + IW'(1);
          state_d  = last_p ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    n_q    <= n_d;
    dt_q   <= dt_d;
    ent_q  <= ent_d;
    step_q <= step_d;
    pos_q  <= pos_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sum_q  <= sum_d;
    ax_q   <= ax_d;
    len_q  <= len_d;
    quo_q  <= quo_d;
    mv_q   <= mv_d;
    if (out_load) begin
      odata_q <= odata_d;
      orst_q  <= orst_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid_o   = ov_q;
  assign m_axis_tdata_o    = odata_q;
  assign m_axis_tuser_o[0] = orst_q;
  assign m_axis_tlast_o    = olast_q;

  pmu_ram #(
    .WIDTH ($bits(pmu_entry_t)),
    .DEPTH (MAX_PARTICLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  pmu_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  pmu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i ({mag_q[ax_q], 16'd0}),
    .divisor_i  (len_q),
    .done_o     (dv_done),
    .quotient_o (dv_quo)
  );

endmodule

`default_nettype wire
